// File: hw/rtl/hcpr_pkg.sv
// shared types, codes and constants for the hermite cdf product row block
package hcpr_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int MAX_ORDER_DEF = 8;

    localparam int VALUE_W     = 32;
    localparam int ROW_INDEX_W = 21;
    localparam int ORDER_W     = 4;
    localparam int DIM_REG_W   = 4;
    localparam int COLUMN_W    = 3;
    localparam int TABLE_ROW_W = 3;
    localparam int FRAC_W      = 24;
    localparam int PROD_W      = 2 * VALUE_W;

    localparam int DIV_BITS   = 7;
    localparam int DIV_CYCLES = ROW_INDEX_W / DIV_BITS;
    localparam int DIV_STEP_W = $clog2(DIV_CYCLES);

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [0:0] REG_DIMENSION = 1'b0;
    localparam logic [0:0] REG_MAX_ORDER = 1'b1;

    localparam logic [DIM_REG_W-1:0] DIMENSION_RESET = 4'd1;
    localparam logic [ORDER_W-1:0]   MAX_ORDER_RESET = 4'd8;

    localparam logic signed [VALUE_W-1:0] ONE_Q24  = 32'sh0100_0000;
    localparam logic signed [VALUE_W-1:0] SAT_MAX  = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] SAT_MIN  = 32'sh8000_0000;
    localparam logic signed [PROD_W-1:0]  HALF_Q24 = 64'sh0000_0000_0080_0000;

    typedef enum logic [1:0] {
        CMD_WR_CDF     = 2'd0,
        CMD_WR_DENSITY = 2'd1,
        CMD_WR_HERMITE = 2'd2,
        CMD_COMPUTE    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV,
        ST_READ,
        ST_MUL,
        ST_RND,
        ST_SIGN,
        ST_DONE
    } state_t;

    typedef struct packed {
        cmd_t                      cmd;
        logic [TABLE_ROW_W-1:0]    table_row;
        logic [COLUMN_W-1:0]       column;
        logic signed [VALUE_W-1:0] value;
        logic [ORDER_W-1:0]        order;
        logic [ROW_INDEX_W-1:0]    row_index;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] product;
        logic                      saturated;
        logic                      invalid;
    } rsp_t;

endpackage

// File: hw/rtl/hermite_cdf_product_row_top.sv
// top level of the hermite cdf product row block
//
// Requests arrive on req_valid/req_ready with one req_t each. Commands 0 to 2
// load the cdf, density and hermite tables and give no result. Command 3
// (compute) gives exactly one rsp_t on rsp_valid/rsp_ready.
// Registers dimension (0x0) and max_order (0x4) sit on the APB port; write
// them only while the block is idle.
// A compute runs from acceptance through the sequencer states: each base-d
// digit of the row goes through a shared 7-bit-per-cycle divider and then a
// check; after the last check, each of the d columns takes a table read, a
// 32x32 multiply and a round-and-clamp on the one multiplier, then come a
// sign and a done state. Bad orders go straight from idle to the done state.
// req_ready is high only while the sequencer is idle, so the next request is
// taken at the earliest in the cycle in which rsp_valid rises.
// The result sits in an output register; a new request is taken while it
// waits, and a finished compute holds until the old result has gone.
// Reset sets dimension to 1 and max_order to 8 and empties the output; the
// tables are not cleared and must be written before use.
module hermite_cdf_product_row_top
    import hcpr_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req_data,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int COL_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W  = $clog2(MAX_DIM + 1);
    localparam int ROW_W  = $clog2(MAX_ORDER);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int DEPTH  = MAX_ORDER * (2 ** COL_W);
    localparam int REM_W  = DIM_W + 1;

    localparam logic [ROW_W-1:0] ROW_CDF     = ROW_W'(0);
    localparam logic [ROW_W-1:0] ROW_DENSITY = ROW_W'(1);

    // configuration
    logic [DIM_REG_W-1:0] dimension_reg;
    logic [ORDER_W-1:0]   max_order_reg;
    logic [DIM_W-1:0]     dim_eff;
    logic [ORDER_W-1:0]   ord_eff;

    // sequencer
    state_t                    state_reg, state_next;
    logic [ROW_INDEX_W-1:0]    quo_reg, quo_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [DIV_STEP_W-1:0]     step_reg, step_next;
    logic [ORDER_W-1:0]        digits_reg, digits_next;
    logic [ROW_W-1:0]          cnt_reg [MAX_DIM];
    logic [ROW_W-1:0]          cnt_next [MAX_DIM];
    logic [DIM_W-1:0]          col_reg, col_next;
    logic signed [VALUE_W-1:0] acc_reg, acc_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic                      sat_reg, sat_next;
    logic                      odd_reg, odd_next;
    logic                      invalid_reg, invalid_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    // datapath
    logic [ROW_INDEX_W-1:0]    div_quo;
    logic [REM_W-1:0]          div_rem;
    logic signed [VALUE_W-1:0] ram_rdata_s;
    logic signed [PROD_W-1:0]  mul_full;
    logic signed [PROD_W-1:0]  rnd_sum;
    logic signed [PROD_W-FRAC_W-1:0] rnd_shift;
    logic signed [VALUE_W-1:0] rnd_clamped;
    logic                      rnd_ovf;
    logic [COL_W-1:0]          col_idx;

    // table memory: row 0 cdf, row 1 density, row n hermite row n-2
    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [VALUE_W-1:0]        ram_rdata;
    logic [ROW_W-1:0]          wr_row;
    logic                      wr_ok;
    logic                      req_fire;

    hcpr_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (req_data.value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // apb
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[2])
            REG_DIMENSION: prdata = APB_DATA_W'(dimension_reg);
            REG_MAX_ORDER: prdata = APB_DATA_W'(max_order_reg);
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIMENSION_RESET;
            max_order_reg <= MAX_ORDER_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (paddr[2])
                REG_DIMENSION: dimension_reg <= pwdata[DIM_REG_W-1:0];
                REG_MAX_ORDER: max_order_reg <= pwdata[ORDER_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (dimension_reg == '0)
            dim_eff = DIM_W'(1);
        else if (int'(dimension_reg) > MAX_DIM)
            dim_eff = DIM_W'(MAX_DIM);
        else
            dim_eff = DIM_W'(dimension_reg);

        if (max_order_reg == '0)
            ord_eff = ORDER_W'(1);
        else if (int'(max_order_reg) > MAX_ORDER)
            ord_eff = ORDER_W'(MAX_ORDER);
        else
            ord_eff = max_order_reg;
    end

    // table writes
    assign req_ready = (state_reg == ST_IDLE);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        wr_row = ROW_CDF;
        wr_ok  = 1'b0;
        case (req_data.cmd)
            CMD_WR_CDF:
            begin
                wr_row = ROW_CDF;
                wr_ok  = 1'b1;
            end
            CMD_WR_DENSITY:
            begin
                wr_row = ROW_DENSITY;
                wr_ok  = 1'b1;
            end
            CMD_WR_HERMITE:
            begin
                wr_row = ROW_W'(int'(req_data.table_row) + 2);
                wr_ok  = (int'(req_data.table_row) + 2 < MAX_ORDER);
            end
            default:
            begin
                wr_row = ROW_CDF;
                wr_ok  = 1'b0;
            end
        endcase
    end

    assign ram_we    = req_fire && wr_ok && (int'(req_data.column) < MAX_DIM);
    assign ram_waddr = {wr_row, COL_W'(req_data.column)};

    assign col_idx   = col_reg[COL_W-1:0];
    assign ram_raddr = {cnt_reg[col_idx], col_idx};

    // shared divider, several restoring steps a cycle
    always_comb
    begin
        div_rem = rem_reg;
        div_quo = quo_reg;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            div_rem = {div_rem[REM_W-2:0], div_quo[ROW_INDEX_W-1]};
            div_quo = {div_quo[ROW_INDEX_W-2:0], 1'b0};
            if (div_rem >= REM_W'(dim_eff))
            begin
                div_rem    = div_rem - REM_W'(dim_eff);
                div_quo[0] = 1'b1;
            end
        end
    end

    // shared multiplier with round half up and clamp
    assign ram_rdata_s = $signed(ram_rdata);
    assign mul_full    = acc_reg * ram_rdata_s;
    assign rnd_sum     = prod_reg + HALF_Q24;
    assign rnd_shift   = rnd_sum[PROD_W-1:FRAC_W];
    assign rnd_ovf     = !((&rnd_shift[PROD_W-FRAC_W-1:VALUE_W-1])
                         || (~|rnd_shift[PROD_W-FRAC_W-1:VALUE_W-1]));

    always_comb
    begin
        if (!rnd_ovf)
            rnd_clamped = rnd_shift[VALUE_W-1:0];
        else if (rnd_shift[PROD_W-FRAC_W-1])
            rnd_clamped = SAT_MIN;
        else
            rnd_clamped = SAT_MAX;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        quo_next       = quo_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        digits_next    = digits_reg;
        cnt_next       = cnt_reg;
        col_next       = col_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        sat_next       = sat_reg;
        odd_next       = odd_reg;
        invalid_next   = invalid_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && req_data.cmd == CMD_COMPUTE)
                begin
                    for (int c = 0; c < MAX_DIM; c++)
                        cnt_next[c] = '0;
                    quo_next    = req_data.row_index;
                    rem_next    = '0;
                    step_next   = '0;
                    digits_next = req_data.order - 1'b1;
                    col_next    = '0;
                    acc_next    = ONE_Q24;
                    sat_next    = 1'b0;
                    odd_next    = 1'b0;
                    if (req_data.order == '0 || req_data.order > ord_eff)
                    begin
                        invalid_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        invalid_next = 1'b0;
                        state_next   = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (digits_reg == '0)
                begin
                    if (quo_reg != '0)
                    begin
                        invalid_next = 1'b1;
                        state_next   = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = div_quo;
                rem_next = div_rem;
                if (step_reg == DIV_STEP_W'(DIV_CYCLES - 1))
                begin
                    step_next = '0;
                    rem_next  = '0;
                    cnt_next[div_rem[COL_W-1:0]] =
                        ROW_W'(cnt_reg[div_rem[COL_W-1:0]] + 1'b1);
                    digits_next = digits_reg - 1'b1;
                    state_next  = ST_CHECK;
                end
                else
                begin
                    step_next = DIV_STEP_W'(step_reg + 1'b1);
                end
            end
            ST_READ:
            begin
                odd_next   = odd_reg ^ (cnt_reg[col_idx] != '0);
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                prod_next  = mul_full;
                state_next = ST_RND;
            end
            ST_RND:
            begin
                acc_next = rnd_clamped;
                sat_next = sat_reg | rnd_ovf;
                col_next = DIM_W'(col_reg + 1'b1);
                if (DIM_W'(col_reg + 1'b1) == dim_eff)
                    state_next = ST_SIGN;
                else
                    state_next = ST_READ;
            end
            ST_SIGN:
            begin
                if (odd_reg)
                begin
                    if (acc_reg == SAT_MIN)
                    begin
                        acc_next = SAT_MAX;
                        sat_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = -acc_reg;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.product   = invalid_reg ? '0 : acc_reg;
                    rsp_next.saturated = invalid_reg ? 1'b0 : sat_reg;
                    rsp_next.invalid   = invalid_reg;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        step_reg    <= step_next;
        digits_reg  <= digits_next;
        cnt_reg     <= cnt_next;
        col_reg     <= col_next;
        acc_reg     <= acc_next;
        prod_reg    <= prod_next;
        sat_reg     <= sat_next;
        odd_reg     <= odd_next;
        invalid_reg <= invalid_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    // checks
    a_no_write_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !ram_we)
        else $error("table written during compute");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ || state_reg == ST_MUL || state_reg == ST_RND)
            |-> (col_reg < dim_eff))
        else $error("column counter beyond dimension");

    a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.invalid)
            |-> (rsp_reg.product == '0 && !rsp_reg.saturated))
        else $error("invalid result carries data");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

endmodule

// File: hw/rtl/hcpr_ram.sv
// generic single write port ram with registered read
module hcpr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the hermite cdf product row block: directed table, then random phases
module tb_top;
    import hcpr_pkg::*;

    localparam int HERM_ROWS   = MAX_ORDER_DEF - 2;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 170;
    localparam int PLAN_ROWS   = 25;
    localparam int TAIL_CYCLES = 80;
    localparam int CYCLE_LIMIT = 1_200_000;

    localparam rsp_t RSP_BAD = '{32'sd0, 1'b0, 1'b1};

    typedef logic [MAX_DIM_DEF-1:0][3:0] col_counts_t;

    typedef struct {
        req_t rq;
        bit   typed;
        rsp_t want;
    } plan_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  req_valid;
    logic                  req_ready;
    req_t                  req_data;
    logic                  rsp_valid;
    logic                  rsp_ready;
    rsp_t                  rsp_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic signed [VALUE_W-1:0] cdf_q  [MAX_DIM_DEF];
    logic signed [VALUE_W-1:0] dens_q [MAX_DIM_DEF];
    logic signed [VALUE_W-1:0] herm_q [HERM_ROWS][MAX_DIM_DEF];
    bit                        cdf_set  [MAX_DIM_DEF];
    bit                        dens_set [MAX_DIM_DEF];
    bit                        herm_set [HERM_ROWS][MAX_DIM_DEF];
    logic [DIM_REG_W-1:0]      dim_reg;
    logic [ORDER_W-1:0]        ord_reg;

    rsp_t      pending_rows [$];
    rsp_t      head_row;
    plan_row_t plan [PLAN_ROWS];

    bit idle_en;
    int stall_left;
    int mismatches;
    int cycles;
    int n_writes;
    int n_results;
    int n_sat;
    int n_bad;

    hermite_cdf_product_row_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #4 clk = ~clk;

    function automatic int eff_cols();
        if (dim_reg == 0)
        begin
            return 1;
        end
        if (dim_reg > MAX_DIM_DEF)
        begin
            return MAX_DIM_DEF;
        end
        return int'(dim_reg);
    endfunction

    function automatic int eff_top_order();
        if (ord_reg == 0)
        begin
            return 1;
        end
        if (ord_reg > MAX_ORDER_DEF)
        begin
            return MAX_ORDER_DEF;
        end
        return int'(ord_reg);
    endfunction

    function automatic col_counts_t col_counts(input logic [ORDER_W-1:0] k,
                                               input logic [ROW_INDEX_W-1:0] r, input int d);
        col_counts_t cnt;
        int          rest;
        cnt  = '0;
        rest = int'(r);
        for (int t = 1; t < int'(k); t++)
        begin
            cnt[rest % d] += 1;
            rest = rest / d;
        end
        return cnt;
    endfunction

    function automatic longint clamp_q24(input longint v, inout logic sat);
        if (v > longint'(SAT_MAX))
        begin
            sat = 1'b1;
            return longint'(SAT_MAX);
        end
        if (v < longint'(SAT_MIN))
        begin
            sat = 1'b1;
            return longint'(SAT_MIN);
        end
        return v;
    endfunction

    function automatic rsp_t row_product(input logic [ORDER_W-1:0] k,
                                         input logic [ROW_INDEX_W-1:0] r);
        int          d;
        longint      nrows;
        longint      acc;
        longint      pick;
        col_counts_t cnt;
        bit          odd;
        logic        sat;
        rsp_t        res;
        d     = eff_cols();
        res   = RSP_BAD;
        nrows = 1;
        repeat (int'(k) - 1) nrows *= d;
        if (k == 0 || int'(k) > eff_top_order() || longint'(r) >= nrows)
        begin
            return res;
        end
        cnt = col_counts(k, r, d);
        acc = longint'(ONE_Q24);
        odd = 1'b0;
        sat = 1'b0;
        for (int c = 0; c < d; c++)
        begin
            if (cnt[c] == 0)
            begin
                pick = cdf_q[c];
            end
            else
            begin
                odd  = ~odd;
                pick = (cnt[c] == 1) ? dens_q[c] : herm_q[cnt[c] - 2][c];
            end
            acc = clamp_q24((acc * pick + longint'(HALF_Q24)) >>> FRAC_W, sat);
        end
        if (odd)
        begin
            acc = clamp_q24(-acc, sat);
        end
        res.product   = acc[VALUE_W-1:0];
        res.saturated = sat;
        res.invalid   = 1'b0;
        return res;
    endfunction

    function automatic logic signed [VALUE_W-1:0] draw_q24();
        logic signed [VALUE_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = $urandom;
            1:
            begin
                v = ONE_Q24 + $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                if ($urandom_range(0, 1) != 0)
                begin
                    v = -v;
                end
            end
            2: v = $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
            default: v = ($urandom_range(0, 1) != 0) ? SAT_MAX : SAT_MIN;
        endcase
        return v;
    endfunction

    function automatic req_t mk_write(input cmd_t c, input int trow, input int col,
                                      input logic signed [VALUE_W-1:0] v);
        req_t q;
        q.cmd       = c;
        q.table_row = TABLE_ROW_W'(trow);
        q.column    = COLUMN_W'(col);
        q.value     = v;
        q.order     = ORDER_W'($urandom);
        q.row_index = ROW_INDEX_W'($urandom);
        return q;
    endfunction

    function automatic req_t mk_compute(input logic [ORDER_W-1:0] k,
                                        input logic [ROW_INDEX_W-1:0] r);
        req_t q;
        q.cmd       = CMD_COMPUTE;
        q.table_row = TABLE_ROW_W'($urandom);
        q.column    = COLUMN_W'($urandom);
        q.value     = $urandom;
        q.order     = k;
        q.row_index = r;
        return q;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d, %s: got %h expected %h", n_results, what, got, want);
        mismatches++;
    endtask

    task automatic push_request(input req_t rq, input bit typed, input rsp_t typed_rsp);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            @(negedge clk);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_valid <= 1'b1;
        req_data  <= rq;
        do @(posedge clk); while (!req_ready);
        case (rq.cmd)
            CMD_WR_CDF:
            begin
                cdf_q[rq.column]   = rq.value;
                cdf_set[rq.column] = 1'b1;
                n_writes++;
            end
            CMD_WR_DENSITY:
            begin
                dens_q[rq.column]   = rq.value;
                dens_set[rq.column] = 1'b1;
                n_writes++;
            end
            CMD_WR_HERMITE:
            begin
                if (rq.table_row < HERM_ROWS)
                begin
                    herm_q[rq.table_row][rq.column]   = rq.value;
                    herm_set[rq.table_row][rq.column] = 1'b1;
                end
                n_writes++;
            end
            default: pending_rows.push_back(typed ? typed_rsp : row_product(rq.order, rq.row_index));
        endcase
    endtask

    task automatic reg_write(input logic [0:0] idx, input logic [DIM_REG_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {28'($urandom), val};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_DIMENSION)
        begin
            dim_reg = val;
        end
        else
        begin
            ord_reg = val;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        while (pending_rows.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_rows.size() == 0)
            begin
                flag_mismatch("unexpected result", rsp_data.product, 32'd0);
            end
            else
            begin
                head_row = pending_rows.pop_front();
                if (rsp_data.product !== head_row.product)
                begin
                    flag_mismatch("product", rsp_data.product, head_row.product);
                end
                if (rsp_data.saturated !== head_row.saturated)
                begin
                    flag_mismatch("saturated", 32'(rsp_data.saturated), 32'(head_row.saturated));
                end
                if (rsp_data.invalid !== head_row.invalid)
                begin
                    flag_mismatch("invalid", 32'(rsp_data.invalid), 32'(head_row.invalid));
                end
                n_results++;
                n_sat += int'(head_row.saturated);
                n_bad += int'(head_row.invalid);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timed out with %0d results outstanding", pending_rows.size());
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 4);
                rsp_ready <= 1'b0;
            end
            else
            begin
                rsp_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int                     phase_dim [N_PHASES];
        int                     phase_ord [N_PHASES];
        int                     d;
        int                     mo;
        int                     k;
        longint                 nrows;
        logic [ROW_INDEX_W-1:0] r;
        col_counts_t            cnt;

        clk        = 1'b0;
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        dim_reg    = DIMENSION_RESET;
        ord_reg    = MAX_ORDER_RESET;
        idle_en    = 1'b1;
        stall_left = 0;
        mismatches = 0;
        cycles     = 0;
        n_writes   = 0;
        n_results  = 0;
        n_sat      = 0;
        n_bad      = 0;

        phase_dim = '{2, 8, 0, 15, 3, 8, 5, 1, 0, 0};
        phase_ord = '{8, 8, 3, 15, 0, 1, 4, 2, 0, 0};
        phase_dim[N_PHASES-2] = $urandom_range(0, 15);
        phase_ord[N_PHASES-2] = $urandom_range(0, 15);
        phase_dim[N_PHASES-1] = $urandom_range(0, 15);
        phase_ord[N_PHASES-1] = $urandom_range(0, 15);

        // reset settings: one column, orders up to eight
        plan[0]  = '{mk_compute(0, 0), 1'b1, RSP_BAD};
        plan[1]  = '{mk_compute(9, 0), 1'b1, RSP_BAD};
        plan[2]  = '{mk_compute(15, 21'h1F_FFFF), 1'b1, RSP_BAD};
        plan[3]  = '{mk_compute(2, 1), 1'b1, RSP_BAD};
        plan[4]  = '{mk_compute(1, 21'h1F_FFFF), 1'b1, RSP_BAD};
        plan[5]  = '{mk_write(CMD_WR_CDF, 0, 0, ONE_Q24), 1'b0, RSP_BAD};
        plan[6]  = '{mk_compute(1, 0), 1'b1, '{ONE_Q24, 1'b0, 1'b0}};
        plan[7]  = '{mk_write(CMD_WR_DENSITY, 0, 0, SAT_MIN), 1'b0, RSP_BAD};
        plan[8]  = '{mk_compute(2, 0), 1'b1, '{SAT_MAX, 1'b1, 1'b0}};
        plan[9]  = '{mk_write(CMD_WR_DENSITY, 0, 0, SAT_MAX), 1'b0, RSP_BAD};
        plan[10] = '{mk_compute(2, 0), 1'b1, '{32'sh8000_0001, 1'b0, 1'b0}};
        plan[11] = '{mk_write(CMD_WR_HERMITE, 0, 0, 32'sh0200_0000), 1'b0, RSP_BAD};
        plan[12] = '{mk_write(CMD_WR_HERMITE, 1, 0, SAT_MAX), 1'b0, RSP_BAD};
        plan[13] = '{mk_write(CMD_WR_HERMITE, 2, 0, SAT_MIN), 1'b0, RSP_BAD};
        plan[14] = '{mk_write(CMD_WR_HERMITE, 3, 0, 32'shFFFF_FFFF), 1'b0, RSP_BAD};
        plan[15] = '{mk_write(CMD_WR_HERMITE, 4, 0, 32'sh0080_0000), 1'b0, RSP_BAD};
        plan[16] = '{mk_write(CMD_WR_HERMITE, 5, 0, 32'sh0000_0001), 1'b0, RSP_BAD};
        // hermite rows past the table are dropped
        plan[17] = '{mk_write(CMD_WR_HERMITE, 6, 0, 32'sh1234_5678), 1'b0, RSP_BAD};
        plan[18] = '{mk_write(CMD_WR_HERMITE, 7, 7, 32'sh0000_0000), 1'b0, RSP_BAD};
        for (int i = 0; i < 6; i++)
        begin
            plan[19 + i] = '{mk_compute(ORDER_W'(3 + i), 0), 1'b0, RSP_BAD};
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (plan[i])
        begin
            push_request(plan[i].rq, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            drain();
            idle_en = (p != N_PHASES - 1) && ($urandom_range(0, 4) != 0);
            reg_write(REG_DIMENSION, DIM_REG_W'(phase_dim[p]));
            reg_write(REG_MAX_ORDER, ORDER_W'(phase_ord[p]));
            d  = eff_cols();
            mo = eff_top_order();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 9) < 4)
                begin
                    push_request(mk_write(cmd_t'($urandom_range(0, 2)), $urandom_range(0, 7),
                                          $urandom_range(0, 7), draw_q24()), 1'b0, RSP_BAD);
                end
                else
                begin
                    if ($urandom_range(0, 7) == 0)
                    begin
                        k = ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(mo + 1, 15);
                    end
                    else
                    begin
                        k = $urandom_range(1, mo);
                    end
                    nrows = 1;
                    repeat (k - 1) nrows *= d;
                    if ($urandom_range(0, 7) == 0 || nrows > (64'd1 << ROW_INDEX_W))
                    begin
                        r = ROW_INDEX_W'($urandom);
                    end
                    else
                    begin
                        r = ROW_INDEX_W'($urandom_range(0, 32'(nrows - 1)));
                    end
                    // load any table entry this row reads that is still unwritten
                    if (k != 0 && k <= mo && longint'(r) < nrows)
                    begin
                        cnt = col_counts(ORDER_W'(k), r, d);
                        for (int c = 0; c < d; c++)
                        begin
                            if (cnt[c] == 0 && !cdf_set[c])
                            begin
                                push_request(mk_write(CMD_WR_CDF, 0, c, draw_q24()), 1'b0, RSP_BAD);
                            end
                            else if (cnt[c] == 1 && !dens_set[c])
                            begin
                                push_request(mk_write(CMD_WR_DENSITY, 0, c, draw_q24()),
                                             1'b0, RSP_BAD);
                            end
                            else if (cnt[c] >= 2 && !herm_set[cnt[c] - 2][c])
                            begin
                                push_request(mk_write(CMD_WR_HERMITE, cnt[c] - 2, c, draw_q24()),
                                             1'b0, RSP_BAD);
                            end
                        end
                    end
                    push_request(mk_compute(ORDER_W'(k), r), 1'b0, RSP_BAD);
                end
            end
        end
        drain();

        $display("%0d table writes and %0d row results checked across %0d register settings",
                 n_writes, n_results, N_PHASES + 1);
        $display("%0d results saturated, %0d flagged invalid, %0d mismatches",
                 n_sat, n_bad, mismatches);
        if (mismatches == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
